[hw/rtl/pls_pkg.sv]
`timescale 1ns / 1ps

package pls_pkg;

	// list geometry
	localparam int CAPACITY      = 16;
	localparam int ELEMENT_WIDTH = 32;

	// fixed port widths
	localparam int FUNC_W = 2;
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 5;

	// derived widths
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef logic [ELEMENT_WIDTH-1:0] elem_t;
	typedef logic [DATA_W-1:0]        data_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CMP_W-1:0]         cmp_t;
	typedef logic [LEN_W-1:0]         len_t;

	// request kinds
	typedef enum logic [FUNC_W-1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_DELETE = 2'd2,
		FUNC_READ   = 2'd3
	} func_t;

	// result codes
	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
	} pls_cmd_t;

endpackage

[hw/rtl/pls_if.sv]
`timescale 1ns / 1ps

// request channel
interface pls_req_if;
	logic                          valid;
	logic                          ready;
	logic [pls_pkg::FUNC_W-1:0]    func;
	logic [pls_pkg::POS_W-1:0]     position;
	logic [pls_pkg::DATA_W-1:0]    value;

	modport source (output valid, func, position, value, input ready);
	modport sink   (input valid, func, position, value, output ready);
endinterface

// response channel
interface pls_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [pls_pkg::DATA_W-1:0]    read_value;
	logic [pls_pkg::STAT_W-1:0]    status;
	logic [pls_pkg::LEN_W-1:0]     length;
	logic                          is_empty;

	modport source (output valid, read_value, status, length, is_empty, input ready);
	modport sink   (input valid, read_value, status, length, is_empty, output ready);
endinterface

[hw/rtl/positional_list_store.sv]
`timescale 1ns / 1ps

// Bounded ordered list of up to CAPACITY elements addressed by 1-based
// position: append, insert (shift back), delete (close gap) and read. Each
// request word yields one response word with the read element, a status
// (done, position out of range, list full) and the length after the request.
// A request is first captured; then the whole cell row shifts or holds in
// parallel and the response register loads, before the next word is taken.
// A pending response
// does not block the next request from being accepted; it only holds the
// shift cycle until the response register is drained.

module positional_list_store (
	input  logic  clk,
	input  logic  arst_n,
	pls_req_if.sink   req,
	pls_rsp_if.source rsp
);

	pls_pkg::pls_cmd_t cmd;

	pls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	pls_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (req.func),
		.position   (req.position),
		.value      (req.value),
		.read_value (rsp.read_value),
		.status     (rsp.status),
		.length     (rsp.length),
		.is_empty   (rsp.is_empty)
	);

endmodule

[hw/rtl/pls_ctrl.sv]
`timescale 1ns / 1ps

module pls_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output pls_pkg::pls_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   slot_free;

	// output register can take a new word
	assign slot_free = !rsp_valid_q || rsp_ready;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// commands to the datapath
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.capture = req_valid;
			S_EXEC: cmd.exec    = slot_free;
			default: cmd = '0;
		endcase
	end

	// state and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_EXEC;
					if (rsp_ready) rsp_valid_q <= 1'b0;
				end
				S_EXEC: begin
					if (slot_free) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/pls_dpath.sv]
`timescale 1ns / 1ps

module pls_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pls_pkg::pls_cmd_t          cmd,
	input  logic [pls_pkg::FUNC_W-1:0] func,
	input  logic [pls_pkg::POS_W-1:0]  position,
	input  logic [pls_pkg::DATA_W-1:0] value,
	output logic [pls_pkg::DATA_W-1:0] read_value,
	output logic [pls_pkg::STAT_W-1:0] status,
	output logic [pls_pkg::LEN_W-1:0]  length,
	output logic                       is_empty
);

	// captured request
	pls_pkg::func_t func_q;
	pls_pkg::cmp_t  pos_q;
	pls_pkg::elem_t val_q;

	// list state
	pls_pkg::elem_t cells_q [pls_pkg::CAPACITY];
	pls_pkg::cnt_t  count_q;

	// result register
	pls_pkg::data_t   read_value_q;
	pls_pkg::status_t status_q;
	pls_pkg::len_t    length_q;
	logic             is_empty_q;

	// decoded request
	pls_pkg::cmp_t    cnt_ext;
	pls_pkg::cmp_t    pos_m1;
	logic             in_range;
	logic             full;
	logic             do_append;
	logic             do_insert;
	logic             do_delete;
	logic             do_read;
	pls_pkg::status_t status_d;
	pls_pkg::cnt_t    count_d;
	pls_pkg::elem_t   rd_elem;
	pls_pkg::elem_t   cells_d [pls_pkg::CAPACITY];

	assign cnt_ext  = pls_pkg::cmp_t'(count_q);
	assign pos_m1   = pos_q - pls_pkg::cmp_t'(1);
	assign in_range = (pos_q != '0) && (pos_q <= cnt_ext);
	assign full     = (cnt_ext == pls_pkg::cmp_t'(pls_pkg::CAPACITY));
	assign rd_elem  = cells_q[pos_m1[pls_pkg::IDX_W-1:0]];

	// request decode, status and next length
	always_comb begin
		do_append = 1'b0;
		do_insert = 1'b0;
		do_delete = 1'b0;
		do_read   = 1'b0;
		status_d  = pls_pkg::ST_DONE;
		count_d   = count_q;
		unique case (func_q)
			pls_pkg::FUNC_APPEND: begin
				if (full) status_d = pls_pkg::ST_FULL;
				else begin
					do_append = 1'b1;
					count_d   = count_q + pls_pkg::cnt_t'(1);
				end
			end
			pls_pkg::FUNC_INSERT: begin
				if (!in_range) status_d = pls_pkg::ST_RANGE;
				else if (full) status_d = pls_pkg::ST_FULL;
				else begin
					do_insert = 1'b1;
					count_d   = count_q + pls_pkg::cnt_t'(1);
				end
			end
			pls_pkg::FUNC_DELETE: begin
				if (!in_range) status_d = pls_pkg::ST_RANGE;
				else begin
					do_delete = 1'b1;
					count_d   = count_q - pls_pkg::cnt_t'(1);
				end
			end
			pls_pkg::FUNC_READ: begin
				if (!in_range) status_d = pls_pkg::ST_RANGE;
				else do_read = 1'b1;
			end
			default: status_d = pls_pkg::ST_DONE;
		endcase
	end

	// each cell picks hold, left neighbor, right neighbor or the new element
	for (genvar g = 0; g < pls_pkg::CAPACITY; g++) begin : g_cell
		localparam pls_pkg::cmp_t IDX = pls_pkg::cmp_t'(g);
		pls_pkg::elem_t prev;
		pls_pkg::elem_t next;

		if (g > 0) begin : g_prev
			assign prev = cells_q[g-1];
		end else begin : g_noprev
			assign prev = '0;
		end

		if (g < pls_pkg::CAPACITY - 1) begin : g_next
			assign next = cells_q[g+1];
		end else begin : g_nonext
			assign next = '0;
		end

		always_comb begin
			cells_d[g] = cells_q[g];
			if (do_append && IDX == cnt_ext) cells_d[g] = val_q;
			if (do_insert) begin
				if (IDX == pos_m1) cells_d[g] = val_q;
				else if (IDX > pos_m1 && IDX <= cnt_ext) cells_d[g] = prev;
			end
			if (do_delete && IDX >= pos_m1 && IDX + pls_pkg::cmp_t'(1) < cnt_ext)
				cells_d[g] = next;
		end
	end

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= pls_pkg::func_t'(func);
			pos_q  <= pls_pkg::cmp_t'(position);
			val_q  <= pls_pkg::elem_t'(value);
		end
	end

	// cell row
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < pls_pkg::CAPACITY; i++) cells_q[i] <= cells_d[i];
		end
	end

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cmd.exec) count_q <= count_d;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			read_value_q <= do_read ? pls_pkg::data_t'(rd_elem) : '0;
			status_q     <= status_d;
			length_q     <= pls_pkg::len_t'(count_d);
			is_empty_q   <= (count_d == '0);
		end
	end

	assign read_value = read_value_q;
	assign status     = status_q;
	assign length     = length_q;
	assign is_empty   = is_empty_q;

endmodule

[hw/rtl/pls_checker.sv]
`timescale 1ns / 1ps

module pls_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [pls_pkg::DATA_W-1:0] read_value,
	input logic [pls_pkg::STAT_W-1:0] status,
	input logic [pls_pkg::LEN_W-1:0]  length,
	input logic                       is_empty
);

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(status)
			&& $stable(length) && $stable(is_empty))
		else $error("response word changed while stalled");

	// empty flag matches the length
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (length == '0)))
		else $error("empty flag disagrees with length");

	// length never exceeds the capacity
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pls_pkg::CAPACITY'(length) <= pls_pkg::CAPACITY))
		else $error("length beyond capacity");

	// failed requests return no element
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != pls_pkg::ST_DONE |-> read_value == '0)
		else $error("element returned on a failed request");

	// full status only at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == pls_pkg::ST_FULL
			|-> (pls_pkg::CAPACITY'(length) == pls_pkg::CAPACITY))
		else $error("full reported below capacity");

endmodule

bind positional_list_store pls_checker u_pls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.read_value (rsp.read_value),
	.status     (rsp.status),
	.length     (rsp.length),
	.is_empty   (rsp.is_empty)
);
